// ===== rtl/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// ppe_pkg: shared types and constants for the predator-prey fit error block
// Widths, saturation limits, step codes and the sequencer control bundle.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W = 32;               // populations, times, rates
  localparam int OPND_W = DATA_W + 1;       // multiplier operand (residual needs 33)
  localparam int PROD_W = 2 * OPND_W;       // full product
  localparam int WIDE_W = DATA_W + 2;       // sums and differences before clamp
  localparam int SUM_W  = 48;               // squared-residual sum
  localparam int CFG_N  = 4;
  localparam int CFG_AW = $clog2(CFG_N);
  localparam int STEP_N = 8;
  localparam int STEP_W = $clog2(STEP_N);
  localparam int CNT_W  = STEP_W + 1;

  localparam logic signed [PROD_W-1:0] P_S32_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] P_S32_MIN = PROD_W'(-64'sd2147483648);
  localparam logic signed [PROD_W-1:0] P_SUM_MAX = PROD_W'(64'sd281474976710655);
  localparam logic signed [WIDE_W-1:0] W_S32_MAX = WIDE_W'(64'sd2147483647);
  localparam logic signed [WIDE_W-1:0] W_S32_MIN = WIDE_W'(-64'sd2147483648);
  localparam logic [SUM_W-1:0]         SUM_MAX   = {SUM_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_PREY_GROWTH    = CFG_AW'(0);
  localparam logic [CFG_AW-1:0] REG_PREDATION_RATE = CFG_AW'(1);
  localparam logic [CFG_AW-1:0] REG_PREDATOR_DEATH = CFG_AW'(2);
  localparam logic [CFG_AW-1:0] REG_PREDATOR_GAIN  = CFG_AW'(3);

  localparam logic [DATA_W-1:0] PREY_GROWTH_RST    = 32'd1835008;
  localparam logic [DATA_W-1:0] PREDATION_RATE_RST = 32'd458752;
  localparam logic [DATA_W-1:0] PREDATOR_DEATH_RST = 32'd393216;
  localparam logic [DATA_W-1:0] PREDATOR_GAIN_RST  = 32'd131072;

  // Multiplier schedule of one Euler step
  typedef enum logic [STEP_W-1:0] {
    STEP_BY  = 3'd0,   // b * y        -> prey rate
    STEP_DX  = 3'd1,   // d * x        -> predator rate
    STEP_DTX = 3'd2,   // dt * x
    STEP_DTY = 3'd3,   // dt * y
    STEP_XN  = 3'd4,   // (dt*x) * gx  -> new prey
    STEP_YN  = 3'd5,   // (dt*y) * gy  -> new predator
    STEP_RX  = 3'd6,   // prey residual squared
    STEP_RY  = 3'd7    // predator residual squared
  } step_t;

  typedef struct packed {
    logic  capture;    // take the input request into the holding registers
    logic  load;       // first sample: load estimates, clear the run
    logic  dt_en;      // form the time step
    logic  issue;      // start a multiply
    step_t issue_step;
    logic  post;       // product of post_step is ready
    step_t post_step;
    logic  emit;       // close the run and load the output register
  } ctl_t;

endpackage

// ===== rtl/ppe_mul.sv =====
// ----------------------------------------------------------------------------
// ppe_mul: shared signed multiplier
// One 33x33 multiply per issue, registered, then floor-shifted by FRAC_BITS.
// ----------------------------------------------------------------------------
module ppe_mul #(
  parameter int FRAC_BITS = ppe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [ppe_pkg::OPND_W-1:0]   op_a,
  input  logic signed [ppe_pkg::OPND_W-1:0]   op_b,
  output logic signed [ppe_pkg::PROD_W-1:0]   prod_sh
);

  logic signed [ppe_pkg::PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

  // arithmetic shift gives rounding toward minus infinity
  assign prod_sh = prod_r >>> FRAC_BITS;

endmodule

// ===== rtl/ppe_ctrl.sv =====
// ----------------------------------------------------------------------------
// ppe_ctrl: step sequencer
// Accepts one request at a time and walks the shared multiplier schedule.
// ----------------------------------------------------------------------------
module ppe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_first,
  input  logic          in_last,
  input  logic          out_free,
  output ppe_pkg::ctl_t ctl
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_DT     = 5'b00100,
    ST_RUN    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [ppe_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                       last_r, last_nxt;
  logic                       post_vld_r;
  ppe_pkg::step_t             post_step_r;
  logic                       issue;

  assign issue = (state_r == ST_RUN) && !cnt_r[ppe_pkg::STEP_W];

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    last_nxt       = last_r;
    in_tready      = 1'b0;
    ctl            = '0;
    ctl.issue      = issue;
    ctl.issue_step = ppe_pkg::step_t'(cnt_r[ppe_pkg::STEP_W-1:0]);
    ctl.post       = post_vld_r;
    ctl.post_step  = post_step_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.capture = 1'b1;
          last_nxt    = in_last;
          state_nxt   = in_first ? ST_LOAD : ST_DT;
        end
      end
      ST_LOAD: begin
        ctl.load  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_DT: begin
        ctl.dt_en = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + ppe_pkg::CNT_W'(1);
        // last cycle only retires the final product
        if (cnt_r[ppe_pkg::STEP_W]) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      post_vld_r  <= 1'b0;
      post_step_r <= ppe_pkg::STEP_BY;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      post_vld_r  <= issue;
      post_step_r <= ppe_pkg::step_t'(cnt_r[ppe_pkg::STEP_W-1:0]);
    end
  end

endmodule

// ===== rtl/predator_prey_euler_fit_error.sv =====
// ----------------------------------------------------------------------------
// predator_prey_euler_fit_error: Lotka-Volterra Euler fit error
// Integrates prey and predator estimates over observed samples and scores the
// run by its sum of squared residuals, compared with the previous run's sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one observation per request; in_tuser marks the first
//   sample of a run (loads the estimates), in_tlast the last (emits a result).
//   Output stream carries one result per run: the saturating chi-square sum
//   and flags for accept (sum not above the previous run's) and saturation.
//   Rate registers are to be written through cfg_* while the block is idle; it is not enforced.
// Timing:
//   A first-sample request passes through a load state and then the closing
//   state. Any other request forms the time step, runs eight multiplies
//   through the one shared 33x33 multiplier, retires the last product, and has a
//   closing cycle. in_tready is high only while idle. A result appears on the
//   output register the cycle after the closing cycle.
// Reset:
//   Estimates, time and sum clear, the previous sum is set to all ones so the
//   first run accepts, and rate registers take their defaults.
// Stall:
//   A held result does not block new requests; only a run that ends while the
//   previous result is still unread waits in its closing cycle.
// ----------------------------------------------------------------------------
module predator_prey_euler_fit_error #(
  parameter int FRAC_BITS = ppe_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample_time [31:0], prey_obs [63:32], predator_obs [95:64]
  input  logic [3*ppe_pkg::DATA_W-1:0]      in_tdata,
  // first_sample [0]
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // chi_square [47:0]
  output logic [ppe_pkg::SUM_W-1:0]         out_tdata,
  // accepted [0], saturated [1]
  output logic [1:0]                        out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [ppe_pkg::CFG_AW-1:0]        cfg_addr,
  input  logic [ppe_pkg::DATA_W-1:0]        cfg_wdata
);

  localparam int DW = ppe_pkg::DATA_W;
  localparam int OW = ppe_pkg::OPND_W;
  localparam int PW = ppe_pkg::PROD_W;
  localparam int WW = ppe_pkg::WIDE_W;
  localparam int SW = ppe_pkg::SUM_W;

  ppe_pkg::ctl_t ctl;

  logic signed [DW-1:0] a_r, b_r, g_r, d_r;
  logic signed [DW-1:0] t_r, xo_r, yo_r;
  logic signed [DW-1:0] prey_r, pred_r, prev_t_r;
  logic signed [DW-1:0] dt_r, gx_r, gy_r, p2_r, p3_r;
  logic [SW-1:0]        sum_r, prev_sum_r;
  logic                 sat_r;
  logic [SW-1:0]        out_sum_r;
  logic                 out_acc_r, out_sat_r, out_vld_r;

  logic signed [OW-1:0] op_a, op_b;
  logic signed [OW-1:0] rx, ry;
  logic signed [PW-1:0] prod_sh;
  logic signed [WW-1:0] dt_w, lin_w;
  logic signed [DW-1:0] dt_c, f32, lin_c;
  logic                 dt_ovf, f_ovf, lin_ovf, sq_ovf, acc_ovf;
  logic [SW-1:0]        sq48, acc48;
  logic [SW:0]          acc_w;
  logic                 out_free;

  // ---------------------------------------------------------------- control
  assign out_free = !out_vld_r || out_tready;

  ppe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_first  (in_tuser),
    .in_last   (in_tlast),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  // --------------------------------------------------------- operand select
  assign rx = OW'(xo_r) - OW'(prey_r);
  assign ry = OW'(yo_r) - OW'(pred_r);

  always_comb begin
    case (ctl.issue_step)
      ppe_pkg::STEP_BY:  begin op_a = OW'(b_r);  op_b = OW'(pred_r); end
      ppe_pkg::STEP_DX:  begin op_a = OW'(d_r);  op_b = OW'(prey_r); end
      ppe_pkg::STEP_DTX: begin op_a = OW'(dt_r); op_b = OW'(prey_r); end
      ppe_pkg::STEP_DTY: begin op_a = OW'(dt_r); op_b = OW'(pred_r); end
      ppe_pkg::STEP_XN:  begin op_a = OW'(p2_r); op_b = OW'(gx_r);   end
      ppe_pkg::STEP_YN:  begin op_a = OW'(p3_r); op_b = OW'(gy_r);   end
      ppe_pkg::STEP_RX:  begin op_a = rx;        op_b = rx;          end
      ppe_pkg::STEP_RY:  begin op_a = ry;        op_b = ry;          end
      default:           begin op_a = rx;        op_b = rx;          end
    endcase
  end

  ppe_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk     (clk),
    .en      (ctl.issue),
    .op_a    (op_a),
    .op_b    (op_b),
    .prod_sh (prod_sh)
  );

  // ---------------------------------------------------------- post-process
  assign dt_w   = WW'(t_r) - WW'(prev_t_r);
  assign dt_ovf = (dt_w > ppe_pkg::W_S32_MAX) || (dt_w < ppe_pkg::W_S32_MIN);
  assign dt_c   = (dt_w > ppe_pkg::W_S32_MAX) ? DW'(ppe_pkg::W_S32_MAX) :
                  (dt_w < ppe_pkg::W_S32_MIN) ? DW'(ppe_pkg::W_S32_MIN) : DW'(dt_w);

  assign f_ovf = (prod_sh > ppe_pkg::P_S32_MAX) || (prod_sh < ppe_pkg::P_S32_MIN);
  assign f32   = (prod_sh > ppe_pkg::P_S32_MAX) ? DW'(ppe_pkg::P_S32_MAX) :
                 (prod_sh < ppe_pkg::P_S32_MIN) ? DW'(ppe_pkg::P_S32_MIN) : DW'(prod_sh);

  assign sq_ovf = prod_sh > ppe_pkg::P_SUM_MAX;
  assign sq48   = sq_ovf ? ppe_pkg::SUM_MAX : SW'(prod_sh);

  always_comb begin
    case (ctl.post_step)
      ppe_pkg::STEP_BY: lin_w = WW'(a_r) - WW'(f32);
      ppe_pkg::STEP_DX: lin_w = WW'(g_r) - WW'(f32);
      ppe_pkg::STEP_XN: lin_w = WW'(prey_r) + WW'(f32);
      ppe_pkg::STEP_YN: lin_w = WW'(pred_r) - WW'(f32);
      default:          lin_w = WW'(f32);
    endcase
  end

  assign lin_ovf = (lin_w > ppe_pkg::W_S32_MAX) || (lin_w < ppe_pkg::W_S32_MIN);
  assign lin_c   = (lin_w > ppe_pkg::W_S32_MAX) ? DW'(ppe_pkg::W_S32_MAX) :
                   (lin_w < ppe_pkg::W_S32_MIN) ? DW'(ppe_pkg::W_S32_MIN) : DW'(lin_w);

  assign acc_w   = {1'b0, sum_r} + {1'b0, sq48};
  assign acc_ovf = acc_w[SW];
  assign acc48   = acc_ovf ? ppe_pkg::SUM_MAX : acc_w[SW-1:0];

  // ------------------------------------------------------- config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= ppe_pkg::PREY_GROWTH_RST;
      b_r <= ppe_pkg::PREDATION_RATE_RST;
      g_r <= ppe_pkg::PREDATOR_DEATH_RST;
      d_r <= ppe_pkg::PREDATOR_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ppe_pkg::REG_PREY_GROWTH:    a_r <= cfg_wdata;
        ppe_pkg::REG_PREDATION_RATE: b_r <= cfg_wdata;
        ppe_pkg::REG_PREDATOR_DEATH: g_r <= cfg_wdata;
        ppe_pkg::REG_PREDATOR_GAIN:  d_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- request hold
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      t_r  <= in_tdata[DW-1:0];
      xo_r <= in_tdata[2*DW-1:DW];
      yo_r <= in_tdata[3*DW-1:2*DW];
    end
  end

  // ------------------------------------------------------- working values
  always_ff @(posedge clk) begin
    if (ctl.dt_en) begin
      dt_r <= dt_c;
    end
    if (ctl.post) begin
      case (ctl.post_step)
        ppe_pkg::STEP_BY:  gx_r <= lin_c;
        ppe_pkg::STEP_DX:  gy_r <= lin_c;
        ppe_pkg::STEP_DTX: p2_r <= f32;
        ppe_pkg::STEP_DTY: p3_r <= f32;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prey_r     <= '0;
      pred_r     <= '0;
      prev_t_r   <= '0;
      sum_r      <= '0;
      prev_sum_r <= ppe_pkg::SUM_MAX;
      sat_r      <= 1'b0;
    end else begin
      if (ctl.load) begin
        prey_r   <= xo_r;
        pred_r   <= yo_r;
        prev_t_r <= t_r;
        sum_r    <= '0;
        sat_r    <= 1'b0;
      end
      if (ctl.dt_en) begin
        prev_t_r <= t_r;
        if (dt_ovf) begin
          sat_r <= 1'b1;
        end
      end
      if (ctl.post) begin
        case (ctl.post_step)
          ppe_pkg::STEP_BY, ppe_pkg::STEP_DX: begin
            if (f_ovf || lin_ovf) begin
              sat_r <= 1'b1;
            end
          end
          ppe_pkg::STEP_DTX, ppe_pkg::STEP_DTY: begin
            if (f_ovf) begin
              sat_r <= 1'b1;
            end
          end
          ppe_pkg::STEP_XN: begin
            prey_r <= lin_c;
            if (f_ovf || lin_ovf) begin
              sat_r <= 1'b1;
            end
          end
          ppe_pkg::STEP_YN: begin
            pred_r <= lin_c;
            if (f_ovf || lin_ovf) begin
              sat_r <= 1'b1;
            end
          end
          default: begin
            sum_r <= acc48;
            if (sq_ovf || acc_ovf) begin
              sat_r <= 1'b1;
            end
          end
        endcase
      end
      if (ctl.emit) begin
        prev_sum_r <= sum_r;
        sum_r      <= '0;
        sat_r      <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_sum_r <= sum_r;
      out_acc_r <= (sum_r <= prev_sum_r);
      out_sat_r <= sat_r;
    end
  end

  assign out_tdata  = out_sum_r;
  assign out_tuser  = {out_sat_r, out_acc_r};
  assign out_tvalid = out_vld_r;

endmodule
